// File: hdl/sarl_pkg.sv
// Shared types and constants for the sorted address range lookup core.
// Used by sorted_address_range_lookup_core and its testbench; depends on nothing.
package sarl_pkg;

  // Field widths fixed by the interface
  localparam int unsigned ADDR_W   = 64;
  localparam int unsigned SPAN_W   = 32;
  localparam int unsigned WIN_W    = 16;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STAT_W   = 3;
  localparam int unsigned HIDX_W   = 10;
  localparam int unsigned COUNT_W  = 11;
  localparam int unsigned CFG_IDX_W = 1;

  // Request commands
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_DONE = 3'd0;
  localparam logic [STAT_W-1:0] ST_HIT  = 3'd1;
  localparam logic [STAT_W-1:0] ST_MISS = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL = 3'd3;
  localparam logic [STAT_W-1:0] ST_ZERO = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BIAS   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 1'd1;

  // Default containment window for zero-size entries
  localparam logic [WIN_W-1:0] WINDOW_RESET = 16'h1000;

  // One table entry as held in memory
  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [SPAN_W-1:0] span;
  } entry_t;

  // Sequencer states, one-hot
  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_PROBE = 8'b0000_0010,
    S_CMP   = 8'b0000_0100,
    S_SHIFT = 8'b0000_1000,
    S_PUT   = 8'b0001_0000,
    S_LCMP  = 8'b0010_0000,
    S_FIN   = 8'b0100_0000
  } state_t;

endpackage

// File: hdl/sarl_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; contents are undefined until written.
module sarl_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/sorted_address_range_lookup_core.sv
// Clear, rejected insert and unused command go straight to the result. Lookup and insert
// first binary-search the n held entries, each probe a memory read then a compare; a
// lookup then tests the last entry at or below the address, if any; an insert moves the
// later entries up one place and then writes its own. A stalled output holds the request.
// One request is in work at a time; the next is taken the cycle after the result is
// registered. Reset (rst_n low, synchronous) empties the table, sets bias 0, window 4096.
// Depends on sarl_pkg and sarl_ram.
module sorted_address_range_lookup_core #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sarl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sarl_pkg::ADDR_W-1:0]         cfg_data,
  // request channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [sarl_pkg::CMD_W-1:0]          in_command,
  input  logic [sarl_pkg::ADDR_W-1:0]         in_address,
  input  logic [sarl_pkg::SPAN_W-1:0]         in_span,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [sarl_pkg::STAT_W-1:0]         out_status,
  output logic                                out_exact_hit,
  output logic [sarl_pkg::HIDX_W-1:0]         out_hit_index,
  output logic [sarl_pkg::ADDR_W-1:0]         out_match_start,
  output logic [sarl_pkg::SPAN_W-1:0]         out_match_span,
  output logic [sarl_pkg::COUNT_W-1:0]        out_entry_count
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned EW = $bits(sarl_pkg::entry_t);

  // Control state
  sarl_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]    fill_r, fill_nxt;
  logic [CW-1:0]    lo_r, lo_nxt;
  logic [CW-1:0]    hi_r, hi_nxt;
  logic [CW-1:0]    rp_r, rp_nxt;
  logic             pend_r, pend_nxt;
  logic             is_ins_r, is_ins_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [sarl_pkg::ADDR_W-1:0] bias_r;
  logic [sarl_pkg::WIN_W-1:0]  window_r;

  // Payload registers
  logic [CW-1:0]               mid_r, mid_nxt;
  logic [CW-1:0]               wa_r, wa_nxt;
  logic [sarl_pkg::ADDR_W-1:0] key_r, key_nxt;
  logic [sarl_pkg::SPAN_W-1:0] span_r, span_nxt;
  logic [sarl_pkg::STAT_W-1:0] res_status_r, res_status_nxt;
  logic                        res_exact_r, res_exact_nxt;
  logic [sarl_pkg::HIDX_W-1:0] res_index_r, res_index_nxt;
  logic [sarl_pkg::ADDR_W-1:0] res_start_r, res_start_nxt;
  logic [sarl_pkg::SPAN_W-1:0] res_span_r, res_span_nxt;
  logic [sarl_pkg::STAT_W-1:0] out_status_r;
  logic                        out_exact_r;
  logic [sarl_pkg::HIDX_W-1:0] out_index_r;
  logic [sarl_pkg::ADDR_W-1:0] out_start_r;
  logic [sarl_pkg::SPAN_W-1:0] out_span_r;
  logic [sarl_pkg::COUNT_W-1:0] out_count_r;

  // Memory port signals
  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  sarl_pkg::entry_t     ram_wdata, ram_rdata;
  logic [EW-1:0]        ram_rdata_raw;

  // Datapath helpers
  logic                        in_accept, out_accept, out_free;
  logic [CW-1:0]               mid;
  logic [sarl_pkg::ADDR_W-1:0] offset, limit;

  assign in_stall   = (state_r != sarl_pkg::S_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid_r && !out_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign cfg_ready  = 1'b1;
  assign ram_rdata  = sarl_pkg::entry_t'(ram_rdata_raw);

  assign mid    = lo_r + ((hi_r - lo_r) >> 1);
  assign offset = key_r - ram_rdata.start;
  assign limit  = (ram_rdata.span != '0) ? {{(sarl_pkg::ADDR_W-sarl_pkg::SPAN_W){1'b0}},
                                            ram_rdata.span}
                                         : {{(sarl_pkg::ADDR_W-sarl_pkg::WIN_W){1'b0}},
                                            window_r};

  // Table memory: start and size side by side
  sarl_ram #(
    .WIDTH(EW),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata_raw)
  );

  // Sequencer: search, shift, write back, containment test, result
  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    rp_nxt         = rp_r;
    pend_nxt       = pend_r;
    is_ins_nxt     = is_ins_r;
    mid_nxt        = mid_r;
    wa_nxt         = wa_r;
    key_nxt        = key_r;
    span_nxt       = span_r;
    res_status_nxt = res_status_r;
    res_exact_nxt  = res_exact_r;
    res_index_nxt  = res_index_r;
    res_start_nxt  = res_start_r;
    res_span_nxt   = res_span_r;
    out_valid_nxt  = out_accept ? 1'b0 : out_valid_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_re         = 1'b0;
    ram_raddr      = '0;

    case (state_r)
      sarl_pkg::S_IDLE: begin
        if (in_accept) begin
          res_status_nxt = sarl_pkg::ST_DONE;
          res_exact_nxt  = 1'b0;
          res_index_nxt  = '0;
          res_start_nxt  = '0;
          res_span_nxt   = '0;
          lo_nxt         = '0;
          hi_nxt         = fill_r;
          span_nxt       = in_span;
          state_nxt      = sarl_pkg::S_FIN;
          case (in_command)
            sarl_pkg::CMD_CLEAR: begin
              fill_nxt = '0;
            end
            sarl_pkg::CMD_INSERT: begin
              if (in_address == '0) begin
                res_status_nxt = sarl_pkg::ST_ZERO;
              end else if (fill_r == CW'(TABLE_DEPTH)) begin
                res_status_nxt = sarl_pkg::ST_FULL;
              end else begin
                key_nxt    = in_address + bias_r;
                is_ins_nxt = 1'b1;
                state_nxt  = sarl_pkg::S_PROBE;
              end
            end
            sarl_pkg::CMD_LOOKUP: begin
              key_nxt    = in_address;
              is_ins_nxt = 1'b0;
              state_nxt  = sarl_pkg::S_PROBE;
            end
            default: begin
              res_status_nxt = sarl_pkg::ST_DONE;
            end
          endcase
        end
      end

      // Issue a probe read, or finish the search
      sarl_pkg::S_PROBE: begin
        if (lo_r < hi_r) begin
          ram_re    = 1'b1;
          ram_raddr = mid[AW-1:0];
          mid_nxt   = mid;
          state_nxt = sarl_pkg::S_CMP;
        end else if (is_ins_r) begin
          rp_nxt    = fill_r;
          pend_nxt  = 1'b0;
          state_nxt = sarl_pkg::S_SHIFT;
        end else if (lo_r == '0) begin
          res_status_nxt = sarl_pkg::ST_MISS;
          state_nxt      = sarl_pkg::S_FIN;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = AW'(lo_r - CW'(1));
          state_nxt = sarl_pkg::S_LCMP;
        end
      end

      // Narrow the search window
      sarl_pkg::S_CMP: begin
        if (ram_rdata.start <= key_r) begin
          lo_nxt = mid_r + CW'(1);
        end else begin
          hi_nxt = mid_r;
        end
        state_nxt = sarl_pkg::S_PROBE;
      end

      // Move the tail up one place, top entry first
      sarl_pkg::S_SHIFT: begin
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = wa_r[AW-1:0];
          ram_wdata = ram_rdata;
        end
        if (rp_r > lo_r) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(rp_r - CW'(1));
          wa_nxt    = rp_r;
          rp_nxt    = rp_r - CW'(1);
          pend_nxt  = 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = sarl_pkg::S_PUT;
        end
      end

      // Write the new entry into its slot
      sarl_pkg::S_PUT: begin
        ram_we          = 1'b1;
        ram_waddr       = lo_r[AW-1:0];
        ram_wdata.start = key_r;
        ram_wdata.span  = span_r;
        fill_nxt        = fill_r + CW'(1);
        state_nxt       = sarl_pkg::S_FIN;
      end

      // Containment and exact-start test on the candidate entry
      sarl_pkg::S_LCMP: begin
        res_exact_nxt = (ram_rdata.start == key_r);
        if (offset < limit) begin
          res_status_nxt = sarl_pkg::ST_HIT;
          res_index_nxt  = sarl_pkg::HIDX_W'(lo_r - CW'(1));
          res_start_nxt  = ram_rdata.start;
          res_span_nxt   = ram_rdata.span;
        end else begin
          res_status_nxt = sarl_pkg::ST_MISS;
        end
        state_nxt = sarl_pkg::S_FIN;
      end

      // Hand the result to the output register once it is free
      sarl_pkg::S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = sarl_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = sarl_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sarl_pkg::S_IDLE;
      fill_r      <= '0;
      lo_r        <= '0;
      hi_r        <= '0;
      rp_r        <= '0;
      pend_r      <= 1'b0;
      is_ins_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      lo_r        <= lo_nxt;
      hi_r        <= hi_nxt;
      rp_r        <= rp_nxt;
      pend_r      <= pend_nxt;
      is_ins_r    <= is_ins_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_r   <= '0;
      window_r <= sarl_pkg::WINDOW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sarl_pkg::REG_BIAS:   bias_r   <= cfg_data;
        sarl_pkg::REG_WINDOW: window_r <= cfg_data[sarl_pkg::WIN_W-1:0];
        default: begin
          bias_r <= bias_r;
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    mid_r        <= mid_nxt;
    wa_r         <= wa_nxt;
    key_r        <= key_nxt;
    span_r       <= span_nxt;
    res_status_r <= res_status_nxt;
    res_exact_r  <= res_exact_nxt;
    res_index_r  <= res_index_nxt;
    res_start_r  <= res_start_nxt;
    res_span_r   <= res_span_nxt;
    if (state_r == sarl_pkg::S_FIN && out_free) begin
      out_status_r <= res_status_r;
      out_exact_r  <= res_exact_r;
      out_index_r  <= res_index_r;
      out_start_r  <= res_start_r;
      out_span_r   <= res_span_r;
      out_count_r  <= sarl_pkg::COUNT_W'(fill_r);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_exact_hit   = out_exact_r;
  assign out_hit_index   = out_index_r;
  assign out_match_start = out_start_r;
  assign out_match_span  = out_span_r;
  assign out_entry_count = out_count_r;

  // Memory writes happen only while moving or placing entries
  assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == sarl_pkg::S_SHIFT || state_r == sarl_pkg::S_PUT))
    else $error("table write outside shift or put");

  // A shift never reads the entry it writes in the same cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("shift read and write collide");

  // Fill count stays within the table
  assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  // A finished request reaches the output register once it is free
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sarl_pkg::S_FIN && out_free) |=> (out_valid_r && state_r == sarl_pkg::S_IDLE))
    else $error("result not registered");

endmodule

// File: tb/sorted_address_range_lookup_core_test.sv
// Self-checking testbench for sorted_address_range_lookup_core: a shadow range table predicts
// every result while requests run under random bursts, output stalls and register settings.
// Depends on sarl_pkg and the core RTL.
module sorted_address_range_lookup_core_test;

  localparam int unsigned DEPTH = 1024;
  localparam int unsigned AW = sarl_pkg::ADDR_W;
  localparam logic [sarl_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [sarl_pkg::STAT_W-1:0]  status;
    logic                         exact;
    logic [sarl_pkg::HIDX_W-1:0]  index;
    logic [sarl_pkg::ADDR_W-1:0]  start;
    logic [sarl_pkg::SPAN_W-1:0]  span;
    logic [sarl_pkg::COUNT_W-1:0] count;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic [sarl_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [sarl_pkg::ADDR_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic [sarl_pkg::CMD_W-1:0] in_command;
  logic [sarl_pkg::ADDR_W-1:0] in_address;
  logic [sarl_pkg::SPAN_W-1:0] in_span;
  logic out_valid;
  logic out_stall;
  logic [sarl_pkg::STAT_W-1:0] out_status;
  logic out_exact_hit;
  logic [sarl_pkg::HIDX_W-1:0] out_hit_index;
  logic [sarl_pkg::ADDR_W-1:0] out_match_start;
  logic [sarl_pkg::SPAN_W-1:0] out_match_span;
  logic [sarl_pkg::COUNT_W-1:0] out_entry_count;

  // Shadow of the sorted table and its settings
  logic [sarl_pkg::ADDR_W-1:0] shadow_start[$];
  logic [sarl_pkg::SPAN_W-1:0] shadow_span[$];
  logic [sarl_pkg::ADDR_W-1:0] shadow_bias;
  logic [sarl_pkg::WIN_W-1:0] shadow_window;

  outcome_t awaited_outcomes[$];
  int mismatch_count = 0;
  int burst_left = 0;
  int hold_request = 0;
  int hold_left = 0;
  int stall_mode = 0;
  int stall_phase = 0;

  sorted_address_range_lookup_core #(.TABLE_DEPTH(DEPTH)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_command(in_command),
    .in_address(in_address),
    .in_span(in_span),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_exact_hit(out_exact_hit),
    .out_hit_index(out_hit_index),
    .out_match_start(out_match_start),
    .out_match_span(out_match_span),
    .out_entry_count(out_entry_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [sarl_pkg::ADDR_W-1:0] rand_addr();
    return {$urandom, $urandom};
  endfunction

  // Count entries whose start is at or below key (binary search)
  function automatic int unsigned entries_at_or_below(logic [sarl_pkg::ADDR_W-1:0] key);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = 0;
    hi = shadow_start.size();
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (shadow_start[mid] <= key) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  // Apply one request to the shadow table and return the result it must produce
  function automatic outcome_t apply_to_shadow_table(logic [sarl_pkg::CMD_W-1:0] cmd,
                                                     logic [sarl_pkg::ADDR_W-1:0] addr,
                                                     logic [sarl_pkg::SPAN_W-1:0] span);
    outcome_t res;
    int unsigned pos;
    logic [sarl_pkg::ADDR_W-1:0] key;
    logic [sarl_pkg::ADDR_W-1:0] limit;
    res = '0;
    res.status = sarl_pkg::ST_DONE;
    case (cmd)
      sarl_pkg::CMD_CLEAR: begin
        shadow_start.delete();
        shadow_span.delete();
      end
      sarl_pkg::CMD_INSERT: begin
        if (addr == '0) begin
          res.status = sarl_pkg::ST_ZERO;
        end else if (shadow_start.size() >= DEPTH) begin
          res.status = sarl_pkg::ST_FULL;
        end else begin
          key = addr + shadow_bias;
          pos = entries_at_or_below(key);
          shadow_start.insert(pos, key);
          shadow_span.insert(pos, span);
        end
      end
      sarl_pkg::CMD_LOOKUP: begin
        res.status = sarl_pkg::ST_MISS;
        pos = entries_at_or_below(addr);
        if (pos > 0) begin
          pos = pos - 1;
          limit = (shadow_span[pos] != '0) ? {32'h0, shadow_span[pos]}
                                           : {48'h0, shadow_window};
          res.exact = (shadow_start[pos] == addr);
          if (addr - shadow_start[pos] < limit) begin
            res.status = sarl_pkg::ST_HIT;
            res.index = pos[sarl_pkg::HIDX_W-1:0];
            res.start = shadow_start[pos];
            res.span = shadow_span[pos];
          end
        end
      end
      default: ;
    endcase
    res.count = sarl_pkg::COUNT_W'(shadow_start.size());
    return res;
  endfunction

  // Offer one request; keep valid high while the burst lasts, idle between bursts
  task automatic send_request(input logic [sarl_pkg::CMD_W-1:0] cmd,
                              input logic [sarl_pkg::ADDR_W-1:0] addr,
                              input logic [sarl_pkg::SPAN_W-1:0] span);
    outcome_t predicted;
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_address <= addr;
    in_span <= span;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = apply_to_shadow_table(cmd, addr, span);
    awaited_outcomes.insert(awaited_outcomes.size(), predicted);
    burst_left--;
    if (burst_left == 0) in_valid <= 1'b0;
  endtask

  // Drop valid and wait until every result has come back
  task automatic wait_for_idle();
    if (burst_left != 0) begin
      in_valid <= 1'b0;
      burst_left = 0;
    end
    while (awaited_outcomes.size() != 0) @(posedge clk);
  endtask

  // Write both registers back to back while the core is idle
  task automatic program_settings(input logic [sarl_pkg::ADDR_W-1:0] bias,
                                  input logic [sarl_pkg::WIN_W-1:0] window);
    wait_for_idle();
    cfg_valid <= 1'b1;
    cfg_index <= sarl_pkg::REG_BIAS;
    cfg_data <= bias;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= sarl_pkg::REG_WINDOW;
    cfg_data <= {(sarl_pkg::ADDR_W - sarl_pkg::WIN_W)'(rand_addr()), window};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    shadow_bias = bias;
    shadow_window = window;
  endtask

  function automatic logic [sarl_pkg::SPAN_W-1:0] pick_span();
    int r;
    r = $urandom_range(99);
    if (r < 20) return '0;
    if (r < 55) return $urandom_range(1, 256);
    if (r < 65) return '1;
    return $urandom;
  endfunction

  // Raw insert address: wide random, clustered low, duplicate of a held key, or near the top
  function automatic logic [sarl_pkg::ADDR_W-1:0] pick_insert_address();
    int r;
    r = $urandom_range(99);
    if (r < 40) return rand_addr();
    if (r < 70) return AW'($urandom_range(1, 4096));
    if (r < 85 && shadow_start.size() != 0)
      return shadow_start[$urandom_range(shadow_start.size() - 1)] - shadow_bias;
    return {AW{1'b1}} - AW'($urandom_range(0, 4096));
  endfunction

  // Lookup address aimed at a held entry: its start, inside, edges, just below
  function automatic logic [sarl_pkg::ADDR_W-1:0] pick_probe_address();
    int unsigned e;
    logic [sarl_pkg::ADDR_W-1:0] s;
    logic [sarl_pkg::ADDR_W-1:0] lim;
    if (shadow_start.size() == 0 || $urandom_range(9) == 0) return rand_addr();
    e = $urandom_range(shadow_start.size() - 1);
    s = shadow_start[e];
    lim = (shadow_span[e] != '0) ? {32'h0, shadow_span[e]} : {48'h0, shadow_window};
    case ($urandom_range(4))
      0: return s;
      1: return (lim == '0) ? s : s + rand_addr() % lim;
      2: return s + lim;
      3: return s + lim - 1;
      default: return s - 1;
    endcase
  endfunction

  // Random traffic in sessions: clear, then mostly inserts and lookups, some noise
  task automatic run_random_items(input int count);
    int session_left;
    int r;
    session_left = 0;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (session_left == 0) begin
        send_request(sarl_pkg::CMD_CLEAR, rand_addr(), $urandom);
        session_left = $urandom_range(1, 40);
      end else if (r < 45) begin
        send_request(sarl_pkg::CMD_INSERT, pick_insert_address(), pick_span());
      end else if (r < 90) begin
        send_request(sarl_pkg::CMD_LOOKUP, pick_probe_address(), $urandom);
      end else if (r < 95) begin
        send_request(CMD_UNUSED, rand_addr(), $urandom);
      end else begin
        send_request(sarl_pkg::CMD_INSERT, '0, $urandom);
      end
      if (session_left != 0) session_left--;
    end
  endtask

  task automatic test_reset_defaults();
    send_request(sarl_pkg::CMD_LOOKUP, 64'h1, 32'h0);
    send_request(CMD_UNUSED, '1, '1);
    send_request(sarl_pkg::CMD_INSERT, '0, 32'h10);
    send_request(sarl_pkg::CMD_INSERT, 64'h1, 32'h0);
    send_request(sarl_pkg::CMD_LOOKUP, 64'h1, 32'h0);
    send_request(sarl_pkg::CMD_LOOKUP, 64'h1000, 32'h0);
    send_request(sarl_pkg::CMD_LOOKUP, 64'h1001, 32'h0);
    // equal starts: the later insert lands after the earlier one
    send_request(sarl_pkg::CMD_INSERT, 64'h1000, 32'h10);
    send_request(sarl_pkg::CMD_INSERT, 64'h1000, 32'h20);
    send_request(sarl_pkg::CMD_LOOKUP, 64'h1000, 32'h0);
    send_request(sarl_pkg::CMD_LOOKUP, 64'h1018, 32'h0);
    // start + span past 2^64 must not wrap
    send_request(sarl_pkg::CMD_INSERT, '1, '1);
    send_request(sarl_pkg::CMD_LOOKUP, '1, '1);
    send_request(sarl_pkg::CMD_LOOKUP, '0, 32'h0);
    send_request(sarl_pkg::CMD_CLEAR, '1, '1);
  endtask

  task automatic test_register_extremes();
    program_settings(64'hFFFF_FFFF_FFFF_F000, '0);
    send_request(sarl_pkg::CMD_INSERT, 64'h2000, 32'h0);
    send_request(sarl_pkg::CMD_LOOKUP, 64'h1000, 32'h0);
    send_request(sarl_pkg::CMD_INSERT, 64'hFFF, 32'h0);
    program_settings('1, '1);
    send_request(sarl_pkg::CMD_INSERT, 64'h1, 32'h0);
    send_request(sarl_pkg::CMD_LOOKUP, '0, 32'h0);
    send_request(sarl_pkg::CMD_LOOKUP, 64'hFFFE, 32'h0);
    send_request(sarl_pkg::CMD_CLEAR, '0, '0);
  endtask

  task automatic test_random_phases();
    program_settings('0, sarl_pkg::WINDOW_RESET);
    run_random_items(16);
    program_settings(rand_addr(), '0);
    run_random_items(16);
    program_settings('1, '1);
    run_random_items(16);
    program_settings(rand_addr(), sarl_pkg::WIN_W'($urandom));
    run_random_items(16);
  endtask

  // Hold the output for a long stretch so the core backs up into its input
  task automatic test_backpressure();
    hold_request = 400;
    for (int i = 0; i < 16; i++)
      send_request(sarl_pkg::CMD_LOOKUP, pick_probe_address(), $urandom);
  endtask

  // Fill the table to its depth, then push inserts that must be refused
  task automatic test_full_table();
    program_settings(rand_addr(), sarl_pkg::WIN_W'($urandom));
    send_request(sarl_pkg::CMD_CLEAR, rand_addr(), $urandom);
    while (shadow_start.size() < DEPTH) begin
      send_request(sarl_pkg::CMD_INSERT, pick_insert_address(), pick_span());
      if ($urandom_range(31) == 0)
        send_request(sarl_pkg::CMD_LOOKUP, pick_probe_address(), $urandom);
    end
    for (int i = 0; i < 8; i++)
      send_request(sarl_pkg::CMD_INSERT, rand_addr() | 64'h1, pick_span());
    for (int i = 0; i < 24; i++)
      send_request(sarl_pkg::CMD_LOOKUP, pick_probe_address(), $urandom);
    send_request(sarl_pkg::CMD_CLEAR, '0, '0);
  endtask

  task automatic report_field(input string field, input logic [sarl_pkg::ADDR_W-1:0] want,
                              input logic [sarl_pkg::ADDR_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    outcome_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (awaited_outcomes.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0h count %0h",
                 $time, out_status, out_entry_count);
        mismatch_count++;
      end else begin
        want = awaited_outcomes.pop_front();
        report_field("status", AW'(want.status), AW'(out_status));
        report_field("exact_hit", AW'(want.exact), AW'(out_exact_hit));
        report_field("hit_index", AW'(want.index), AW'(out_hit_index));
        report_field("match_start", want.start, out_match_start);
        report_field("match_span", AW'(want.span), AW'(out_match_span));
        report_field("entry_count", AW'(want.count), AW'(out_entry_count));
      end
    end
  end

  // Output stall: long hold on request, otherwise stretches of none, light or heavy stalling
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (stall_phase == 0) begin
        stall_mode = $urandom_range(2);
        stall_phase = $urandom_range(20, 80);
      end else begin
        stall_phase--;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(3) == 0);
        default: out_stall <= ($urandom_range(1) == 0);
      endcase
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = sarl_pkg::REG_BIAS;
    cfg_data = '0;
    in_valid = 1'b0;
    in_command = sarl_pkg::CMD_CLEAR;
    in_address = '0;
    in_span = '0;
    out_stall = 1'b0;
    shadow_bias = '0;
    shadow_window = sarl_pkg::WINDOW_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_register_extremes();
    test_random_phases();
    test_backpressure();
    test_full_table();
    wait_for_idle();
    repeat (16) @(posedge clk);
    if (mismatch_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #150000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// File: sorted_address_range_lookup_core.f
hdl/sarl_pkg.sv
hdl/sarl_ram.sv
hdl/sorted_address_range_lookup_core.sv
tb/sorted_address_range_lookup_core_test.sv
